>>> hdl/meit_pkg.sv
package meit_pkg;

    localparam int VERT_W        = 10;
    localparam int COUNT_W       = 8;
    localparam int TOTAL_W       = 14;
    localparam int SLOT_W        = COUNT_W + VERT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_SHARED = COUNT_W'(2);

    localparam int VERTS_DEFAULT = 1024;
    localparam int SLOTS_DEFAULT = 8;

endpackage

>>> hdl/meit_ram.sv
module meit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hdl/mesh_edge_incidence_table.sv
// Edge incidence table for triangle meshes. Each input word is one triangle;
// its edges (a,b), (b,c), (a,c) are filed under the smaller vertex, in a row
// of SLOTS slots held in one word of a single-port row memory. Each edge is
// one row read followed by a row write if a slot is found; a triangle goes
// through accept, 3 x read/update and result before the next is accepted.
// The output word holds the running count of edges with three or more faces,
// a sticky row-overflow flag, and an echo of last_face. After reset, and after
// each word with last_face set, the block clears the row memory one row per
// cycle (all VERTS rows, 1024 by default) and holds s_ready low meanwhile.
module mesh_edge_incidence_table
    import meit_pkg::*;
#(
    parameter int VERTS = VERTS_DEFAULT,
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VERT_W-1:0]  s_vert_a,
    input  logic [VERT_W-1:0]  s_vert_b,
    input  logic [VERT_W-1:0]  s_vert_c,
    input  logic               s_last_face,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TOTAL_W-1:0] m_nonmanifold_total,
    output logic               m_row_overflow,
    output logic               m_mesh_done
);

    localparam int AW    = $clog2(VERTS);
    localparam int ROW_W = SLOTS * SLOT_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [1:0] EDGE_LAST = 2'd2;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [1:0]         edge_reg, edge_next;
    logic [VERT_W-1:0]  va_reg, vb_reg, vc_reg;
    logic               last_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic               m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0] m_total_reg;
    logic               m_ovf_reg, m_done_reg;

    logic [VERT_W-1:0]  p, q, row_v, end_v;
    logic               in_range;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [ROW_W-1:0]   ram_wdata, ram_rdata;
    logic               hit, taken;
    logic [SLOTS-1:0]   sel;
    logic [COUNT_W-1:0] old_cnt, new_cnt;
    logic [ROW_W-1:0]   upd_row;
    logic               accept_in, load_out;

    meit_ram #(
        .WIDTH(ROW_W),
        .DEPTH(VERTS)
    ) u_rows (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // Current edge: (a,b), (b,c), (a,c).
    always_comb begin
        unique case (edge_reg)
            2'd0:    begin p = va_reg; q = vb_reg; end
            2'd1:    begin p = vb_reg; q = vc_reg; end
            default: begin p = va_reg; q = vc_reg; end
        endcase
        if (p < q) begin
            row_v = p;
            end_v = q;
        end else begin
            row_v = q;
            end_v = p;
        end
        in_range = 32'(row_v) < VERTS;
    end

    // First slot in the row that matches the end vertex or is empty.
    always_comb begin
        taken   = 1'b0;
        old_cnt = '0;
        for (int k = 0; k < SLOTS; k++) begin
            sel[k] = 1'b0;
            if (!taken && (ram_rdata[k*SLOT_W +: VERT_W] == end_v ||
                           ram_rdata[k*SLOT_W+VERT_W +: COUNT_W] == '0)) begin
                sel[k]  = 1'b1;
                taken   = 1'b1;
                old_cnt = ram_rdata[k*SLOT_W+VERT_W +: COUNT_W];
            end
        end
        hit     = taken;
        new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_W'(1);
        upd_row = ram_rdata;
        for (int k = 0; k < SLOTS; k++) begin
            if (sel[k]) begin
                upd_row[k*SLOT_W +: SLOT_W] = {new_cnt, end_v};
            end
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept_in = s_valid && s_ready;
    assign load_out  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        edge_next    = edge_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        ram_we       = 1'b0;
        ram_addr     = AW'(row_v);
        ram_wdata    = upd_row;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                if (clr_reg == AW'(VERTS - 1)) begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (accept_in) begin
                    edge_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (in_range) begin
                    if (hit) begin
                        ram_we = 1'b1;
                        if (old_cnt == COUNT_SHARED && total_reg != TOTAL_MAX) begin
                            total_next = total_reg + TOTAL_W'(1);
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                if (edge_reg == EDGE_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    edge_next  = edge_reg + 2'd1;
                    state_next = ST_READ;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    if (last_reg) begin
                        total_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            edge_reg    <= '0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            edge_reg    <= edge_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            va_reg   <= s_vert_a;
            vb_reg   <= s_vert_b;
            vc_reg   <= s_vert_c;
            last_reg <= s_last_face;
        end
        if (load_out) begin
            m_total_reg <= total_reg;
            m_ovf_reg   <= ovf_reg;
            m_done_reg  <= last_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_nonmanifold_total = m_total_reg;
    assign m_row_overflow      = m_ovf_reg;
    assign m_mesh_done         = m_done_reg;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import meit_pkg::*;

    localparam int VERTS       = VERTS_DEFAULT;
    localparam int SLOTS       = SLOTS_DEFAULT;
    localparam int TABLE_DEPTH = VERTS * SLOTS;
    localparam int ITEM_TARGET = 1650;
    localparam int MAX_GAP     = 19;
    localparam int DRAIN_TAIL  = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT_NS    = 6_000_000;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               overflow;
        logic               done;
    } tally_t;

    typedef enum {
        MESH_SPARSE,
        MESH_DENSE,
        MESH_STRIP,
        MESH_HAMMER
    } mesh_style_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [VERT_W-1:0]  s_vert_a    = '0;
    logic [VERT_W-1:0]  s_vert_b    = '0;
    logic [VERT_W-1:0]  s_vert_c    = '0;
    logic               s_last_face = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [TOTAL_W-1:0] m_nonmanifold_total;
    logic               m_row_overflow;
    logic               m_mesh_done;

    // Shadow copy of the incidence table and the running totals.
    logic [VERT_W-1:0]  end_vertex [TABLE_DEPTH];
    logic [COUNT_W-1:0] face_count [TABLE_DEPTH];
    logic [TOTAL_W-1:0] shared_total;
    logic               sticky_overflow;

    tally_t pending_tallies[$];
    int     failures   = 0;
    int     items_sent = 0;
    bit     tx_idle_on = 1'b1;
    bit     rx_idle_on = 1'b1;
    int     rx_hold    = 0;

    mesh_edge_incidence_table #(
        .VERTS(VERTS),
        .SLOTS(SLOTS)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_vert_a           (s_vert_a),
        .s_vert_b           (s_vert_b),
        .s_vert_c           (s_vert_c),
        .s_last_face        (s_last_face),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_nonmanifold_total(m_nonmanifold_total),
        .m_row_overflow     (m_row_overflow),
        .m_mesh_done        (m_mesh_done)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    function automatic void clear_table();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            end_vertex[i] = '0;
            face_count[i] = '0;
        end
        shared_total    = '0;
        sticky_overflow = 1'b0;
    endfunction

    // Files one edge under its smaller vertex; the first slot that holds the
    // same end or is still empty takes it.
    function automatic void file_edge(input logic [VERT_W-1:0] p, input logic [VERT_W-1:0] q);
        logic [VERT_W-1:0] row;
        logic [VERT_W-1:0] tail;
        int                base;
        row  = (p < q) ? p : q;
        tail = (p < q) ? q : p;
        if (int'(row) >= VERTS)
            return;
        base = int'(row) * SLOTS;
        for (int k = 0; k < SLOTS; k++) begin
            if (end_vertex[base + k] == tail || face_count[base + k] == '0) begin
                end_vertex[base + k] = tail;
                if (face_count[base + k] != COUNT_MAX) begin
                    face_count[base + k] = face_count[base + k] + 1'b1;
                    if (face_count[base + k] == COUNT_SHARED + 1'b1 && shared_total != TOTAL_MAX)
                        shared_total = shared_total + 1'b1;
                end
                return;
            end
        end
        sticky_overflow = 1'b1;
    endfunction

    function automatic void file_triangle(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b,
                                          input logic [VERT_W-1:0] c, input logic last);
        tally_t t;
        file_edge(a, b);
        file_edge(b, c);
        file_edge(a, c);
        t.total    = shared_total;
        t.overflow = sticky_overflow;
        t.done     = last;
        pending_tallies.push_back(t);
        if (last)
            clear_table();
    endfunction

    task automatic offer_triangle(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b,
                                  input logic [VERT_W-1:0] c, input logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_vert_a    <= a;
        s_vert_b    <= b;
        s_vert_c    <= c;
        s_last_face <= last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        file_triangle(a, b, c, last);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_tallies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    initial begin : result_checker
        tally_t want;
        int     gap;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                gap     = rx_hold;
                rx_hold = 0;
            end else begin
                gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            repeat (gap) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_tallies.size() == 0) begin
                $error("unexpected word: nonmanifold_total %0d row_overflow %0d mesh_done %0d",
                       m_nonmanifold_total, m_row_overflow, m_mesh_done);
                failures++;
            end else begin
                want = pending_tallies.pop_front();
                if (m_nonmanifold_total !== want.total) begin
                    $error("nonmanifold_total: expected %0d, actual %0d",
                           want.total, m_nonmanifold_total);
                    failures++;
                end
                if (m_row_overflow !== want.overflow) begin
                    $error("row_overflow: expected %0d, actual %0d",
                           want.overflow, m_row_overflow);
                    failures++;
                end
                if (m_mesh_done !== want.done) begin
                    $error("mesh_done: expected %0d, actual %0d", want.done, m_mesh_done);
                    failures++;
                end
            end
        end
    end

    task automatic send_mesh(input mesh_style_t style, input int len);
        int                width;
        logic [VERT_W-1:0] base;
        logic [VERT_W-1:0] a;
        logic [VERT_W-1:0] b;
        logic [VERT_W-1:0] c;
        logic [VERT_W-1:0] ha;
        logic [VERT_W-1:0] hc;
        width = $urandom_range(3, 12);
        base  = VERT_W'($urandom_range(0, (1 << VERT_W) - 1 - width));
        ha    = VERT_W'($urandom_range(0, (1 << VERT_W) - 1));
        hc    = $urandom_range(0, 1) ? ha : VERT_W'($urandom_range(0, (1 << VERT_W) - 1));
        for (int i = 0; i < len; i++) begin
            case (style)
                MESH_SPARSE: begin
                    a = VERT_W'($urandom_range(0, (1 << VERT_W) - 1));
                    b = VERT_W'($urandom_range(0, (1 << VERT_W) - 1));
                    c = VERT_W'($urandom_range(0, (1 << VERT_W) - 1));
                end
                MESH_DENSE: begin
                    a = base + VERT_W'($urandom_range(0, width - 1));
                    b = base + VERT_W'($urandom_range(0, width - 1));
                    c = base + VERT_W'($urandom_range(0, width - 1));
                end
                MESH_STRIP: begin
                    // Consecutive triangles of a strip share one edge; the
                    // winding flips every other face, and the indices may wrap.
                    a = base + VERT_W'(i);
                    b = base + VERT_W'(i + ((i % 2) ? 2 : 1));
                    c = base + VERT_W'(i + ((i % 2) ? 1 : 2));
                end
                default: begin
                    // Repeated faces push counts up, to saturation if hc == ha.
                    a = ha;
                    b = ha;
                    c = hc;
                end
            endcase
            offer_triangle(a, b, c, i == len - 1);
        end
    endtask

    task automatic test_shared_edges();
        offer_triangle(10'd1, 10'd2, 10'd3, 1'b0);
        offer_triangle(10'd2, 10'd1, 10'd4, 1'b0);
        offer_triangle(10'd1, 10'd2, 10'd5, 1'b0);
        offer_triangle(10'd2, 10'd1, 10'd6, 1'b0);
        offer_triangle(10'd3, 10'd2, 10'd1, 1'b1);
        wait_drained();
    endtask

    task automatic test_extremes_and_degenerate();
        offer_triangle(10'd1023, 10'd1023, 10'd1023, 1'b0);
        offer_triangle(10'd0, 10'd1023, 10'd0, 1'b0);
        offer_triangle(10'd1023, 10'd0, 10'd512, 1'b0);
        offer_triangle(10'd0, 10'd0, 10'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_row_overflow();
        // Row 5 fills with ends 6 through 13; end 14 then finds no slot.
        offer_triangle(10'd5, 10'd6, 10'd7, 1'b0);
        offer_triangle(10'd5, 10'd8, 10'd9, 1'b0);
        offer_triangle(10'd5, 10'd10, 10'd11, 1'b0);
        offer_triangle(10'd5, 10'd12, 10'd13, 1'b0);
        offer_triangle(10'd5, 10'd14, 10'd14, 1'b0);
        offer_triangle(10'd13, 10'd5, 10'd6, 1'b1);
        offer_triangle(10'd5, 10'd14, 10'd15, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold    = HOLD_CYCLES;
        send_mesh(MESH_DENSE, 40);
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_meshes();
        int          pick;
        mesh_style_t style;
        int          len;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                style = MESH_DENSE;
                len   = $urandom_range(5, 60);
            end else if (pick < 65) begin
                style = MESH_STRIP;
                len   = $urandom_range(5, 40);
            end else if (pick < 90) begin
                style = MESH_SPARSE;
                len   = $urandom_range(5, 30);
            end else begin
                style = MESH_HAMMER;
                len   = $urandom_range(90, 110);
            end
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            send_mesh(style, len);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    initial begin
        clear_table();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_shared_edges();
        test_extremes_and_degenerate();
        test_row_overflow();
        test_backpressure();
        test_random_meshes();
        wait_drained();
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
